/* rtl/core/tsched_pkg.sv */
package tsched_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_PERIODIC = 3'd1;
  localparam logic [2:0] OP_ONESHOT  = 3'd2;
  localparam logic [2:0] OP_IMMED    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;
  localparam logic [2:0] OP_DISPATCH = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_BAD_HNDL  = 3'd4;

  // One slot entry as it is held in the slot memory.
  typedef struct packed {
    logic [31:0] arg;
    logic [7:0]  callback;
    logic [31:0] start;
    logic [15:0] period;
    logic        timed;
    logic        periodic;
  } slot_t;

endpackage

/* rtl/core/tsched_ram.sv */
module tsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/timed_callback_slot_scheduler.sv */
// Callback slot scheduler: a table of SLOTS slots, each holding a mode, a period in ticks,
// a callback id and an argument. Each input word is one operation (tick, schedule
// periodic, one-shot or immediate, clear, dispatch) and yields exactly one result word.
// Slot contents live in a one-read, one-write memory; only the occupancy bits are flops.
// Tick, clear, unused codes, a schedule into a full table and a dispatch on an empty
// table go straight to the finish state. Schedule walks the occupancy bits one slot a
// cycle from the insert pointer. Dispatch reads the slot memory one entry a cycle from
// the service pointer and checks each entry in the cycle after its read. A result that
// finds the output register still full waits in the finish state. A new word is
// accepted whenever the block is idle, even while the last result still waits.
module timed_callback_slot_scheduler
  import tsched_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] op, [18:3] period_ms, [26:19] callback_id, [58:27] user_arg,
  // [62:59] slot_handle, [63] zero
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [3] fired, [7:4] out_handle, [15:8] out_callback, [47:16] out_arg,
  // [52:48] active_count, [57:53] peak_count, [63:58] zero
  output logic [63:0] m_tdata
);

  localparam int IW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int SLOT_W = $bits(slot_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCHED = 2'd1;
  localparam logic [1:0] S_DISP  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]       state;
  logic [SLOTS-1:0] slot_active;
  logic [IW-1:0]    insert_ptr;
  logic [IW-1:0]    service_ptr;
  logic [CW-1:0]    occupancy;
  logic [CW-1:0]    occupancy_peak;
  logic [31:0]      now_ticks;

  // Latched operation
  logic [2:0]  op;
  logic [15:0] period_ms;
  logic [7:0]  callback_id;
  logic [31:0] user_arg;

  // Walk state
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] iss_idx;
  logic [CW-1:0] iss_cnt;
  logic          chk_vld;
  logic          chk_last;
  logic [IW-1:0] chk_idx;

  // Result held until the output register is free
  logic [2:0]  res_status;
  logic        res_fired;
  logic [3:0]  res_handle;
  logic [7:0]  res_callback;
  logic [31:0] res_arg;

  logic [2:0]  out_status;
  logic        out_fired;
  logic [3:0]  out_handle;
  logic [7:0]  out_callback;
  logic [31:0] out_arg;
  logic [4:0]  active_count;
  logic [4:0]  peak_count;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  slot_t             ram_wslot;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_slot;
  logic [31:0]       elapsed;
  logic              hit;
  logic              sched_free;
  logic [IW-1:0]     in_hidx;
  logic [CW-1:0]     occ_inc;

  logic [2:0]  in_op;
  logic [3:0]  in_handle;

  assign in_op     = s_tdata[2:0];
  assign in_handle = s_tdata[62:59];
  assign in_hidx   = IW'(in_handle);
  assign occ_inc   = occupancy + 1'b1;

  assign s_tready = (state == S_IDLE);

  assign rd_slot = slot_t'(ram_rdata);
  assign elapsed = now_ticks - rd_slot.start;

  always_comb begin
    hit = (state == S_DISP) && chk_vld && slot_active[chk_idx] &&
          (!rd_slot.timed || (elapsed >= {16'b0, rd_slot.period}));
    sched_free = (state == S_SCHED) && !slot_active[scan_idx];
    ram_we     = 1'b0;
    ram_waddr  = scan_idx;
    ram_wslot  = rd_slot;
    if (sched_free) begin
      ram_we             = 1'b1;
      ram_wslot.arg      = user_arg;
      ram_wslot.callback = callback_id;
      ram_wslot.start    = now_ticks;
      ram_wslot.period   = (op == OP_IMMED) ? 16'd0 : period_ms;
      ram_wslot.timed    = (op != OP_IMMED);
      ram_wslot.periodic = (op == OP_PERIODIC);
    end else if (hit) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx;
      if (rd_slot.timed) begin
        ram_wslot.start = now_ticks;
      end
    end
  end

  tsched_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wslot),
    .raddr(iss_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_active    <= '0;
      insert_ptr     <= '0;
      service_ptr    <= '0;
      occupancy      <= '0;
      occupancy_peak <= '0;
      now_ticks      <= '0;
      m_tvalid       <= 1'b0;
      chk_vld        <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op           <= in_op;
            period_ms    <= s_tdata[18:3];
            callback_id  <= s_tdata[26:19];
            user_arg     <= s_tdata[58:27];
            res_fired    <= 1'b0;
            res_handle   <= '0;
            res_callback <= '0;
            res_arg      <= '0;
            case (in_op)
              OP_TICK: begin
                now_ticks  <= now_ticks + 1'b1;
                res_status <= ST_OK;
                state      <= S_FIN;
              end
              OP_PERIODIC, OP_ONESHOT, OP_IMMED: begin
                if (occupancy == FULL_CNT) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  scan_idx   <= insert_ptr;
                  state      <= S_SCHED;
                end
              end
              OP_CLEAR: begin
                state <= S_FIN;
                if ((32'(in_handle) >= SLOTS) || (occupancy == '0)) begin
                  res_status <= ST_BAD_HNDL;
                end else begin
                  res_status <= ST_OK;
                  if (slot_active[in_hidx]) begin
                    slot_active[in_hidx] <= 1'b0;
                    occupancy            <= occupancy - 1'b1;
                  end
                end
              end
              OP_DISPATCH: begin
                if (occupancy == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  iss_idx    <= service_ptr;
                  iss_cnt    <= '0;
                  chk_vld    <= 1'b0;
                  state      <= S_DISP;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end

        S_SCHED: begin
          // A free slot is known to exist, so this walk always ends.
          if (sched_free) begin
            slot_active[scan_idx] <= 1'b1;
            insert_ptr            <= next_idx(scan_idx);
            occupancy             <= occ_inc;
            if (occ_inc > occupancy_peak) begin
              occupancy_peak <= occ_inc;
            end
            res_handle <= 4'(scan_idx);
            state      <= S_FIN;
          end else begin
            scan_idx <= next_idx(scan_idx);
          end
        end

        S_DISP: begin
          // One entry is read per cycle; the entry read last cycle is checked now.
          // A check flag left set after a hit is harmless: hit also needs this state.
          if (iss_cnt != FULL_CNT) begin
            iss_idx  <= next_idx(iss_idx);
            iss_cnt  <= iss_cnt + 1'b1;
            chk_idx  <= iss_idx;
            chk_last <= (iss_cnt == LAST_CNT);
            chk_vld  <= 1'b1;
          end else begin
            chk_vld <= 1'b0;
          end
          if (hit) begin
            service_ptr  <= next_idx(chk_idx);
            res_fired    <= 1'b1;
            res_handle   <= 4'(chk_idx);
            res_callback <= rd_slot.callback;
            res_arg      <= rd_slot.arg;
            if (!rd_slot.periodic) begin
              slot_active[chk_idx] <= 1'b0;
              occupancy            <= occupancy - 1'b1;
            end
            state <= S_FIN;
          end else if (chk_vld && chk_last) begin
            res_status <= ST_NOT_READY;
            state      <= S_FIN;
          end
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid     <= 1'b1;
            out_status   <= res_status;
            out_fired    <= res_fired;
            out_handle   <= res_handle;
            out_callback <= res_callback;
            out_arg      <= res_arg;
            active_count <= 5'(occupancy);
            peak_count   <= 5'(occupancy_peak);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {6'b0, peak_count, active_count, out_arg, out_callback, out_handle,
                    out_fired, out_status};

endmodule
